>>> hdl/lpmr_pkg.sv
// Shared types, constants and a helper function of the length-prefixed message ring.
package lpmr_pkg;

	localparam int BUFFER_BYTES  = 1024;
	localparam int RESERVE_BYTES = 4;
	localparam int HDR_BYTES     = 4;

	localparam int BYTE_W     = 8;
	localparam int SIZE_W     = 11;
	localparam int STATUS_W   = 2;
	localparam int POS_W      = $clog2(BUFFER_BYTES);
	localparam int LANE_W     = $clog2(HDR_BYTES);
	localparam int WORD_W     = BYTE_W * HDR_BYTES;
	localparam int NUM_BANKS  = 2;
	localparam int BANK_DEPTH = BUFFER_BYTES / (HDR_BYTES * NUM_BANKS);
	localparam int BANK_AW    = $clog2(BANK_DEPTH);
	localparam int CHK_W      = ((POS_W + 1) > SIZE_W ? (POS_W + 1) : SIZE_W) + 1;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_IGNORED  = 2'd3
	} status_t;

	typedef struct packed {
		logic              opcode;
		logic              push_start;
		logic [SIZE_W-1:0] msg_size;
		logic [BYTE_W-1:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic [SIZE_W-1:0] popped_size;
		logic              end_of_message;
		status_t           status;
	} rsp_t;

	typedef struct packed {
		logic [HDR_BYTES-1:0] be;
		logic [BANK_AW-1:0]   waddr;
		logic [WORD_W-1:0]    wdata;
		logic                 re;
		logic [BANK_AW-1:0]   raddr;
	} bank_req_t;

	// Round a ring position up to the next header boundary, wrapping to zero at the end.
	function automatic logic [POS_W-1:0] round_pos(input logic [POS_W-1:0] p);
		logic [POS_W-1:0] s;
		s = p + POS_W'(HDR_BYTES - 1);
		return {s[POS_W-1:LANE_W], {LANE_W{1'b0}}};
	endfunction

endpackage

>>> hdl/length_prefixed_message_ring.sv
// Top level of the length-prefixed message ring: control, pointers and result register.
//
// The request channel (req_valid, req_ready, req) carries one push byte or one pop request
// per transaction; the response channel (rsp_valid, rsp_ready, rsp) returns exactly one
// result per request, in order. Pushed messages are stored with a four-byte length header
// and become visible to pops only after their last byte; a message that does not fit,
// with the reserve kept free, is rejected on its first byte and its other bytes ignored.
// Each request passes from the request register to the response register. Throughput is
// one request per cycle while the receiver does not stall, except that a pop which opens
// a message occupies the request register while the header word is read from the store
// and then the first message byte (one read port per bank).
// The store is two word-interleaved banks with a registered read, so a header and the
// first data byte of a push go into different banks in the same cycle.
// Reset clears all pointers and counters and leaves the ring empty; store contents are
// not cleared and need no clearing pass. When the receiver stalls, the response register
// holds its transaction and the request register can still take one more request.
module length_prefixed_message_ring (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  lpmr_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output lpmr_pkg::rsp_t rsp
);
	import lpmr_pkg::*;

	// Request register
	logic req_vld_s1;
	req_t req_s1;

	// Ring state
	logic [POS_W-1:0]  head_q, tail_q, wcur_q, rcur_q;
	logic [SIZE_W-1:0] push_left_q, pop_left_q, pop_len_q;
	logic              push_rej_q;
	logic              hdr_ok_q;

	logic [POS_W-1:0]  head_d, tail_d, wcur_d, rcur_d;
	logic [SIZE_W-1:0] push_left_d, pop_left_d, pop_len_d;
	logic              push_rej_d;

	// Response register
	logic             rsp_vld_s2;
	rsp_t             rsp_s2;
	logic             byte_vld_s2;
	logic             byte_bank_s2;
	logic [LANE_W-1:0] byte_lane_s2;

	rsp_t rsp_d;
	logic byte_vld_d;

	logic [POS_W-1:0]  used_bytes;
	logic [CHK_W-1:0]  free_bytes, need_bytes;
	logic [SIZE_W-1:0] hdr_size;
	logic              need_fetch, s2_free, s1_fire, fetch_go;
	logic              hdr_we, dat_we, rd_re;
	logic [POS_W-1:0]  dat_pos, rd_pos;

	bank_req_t [NUM_BANKS-1:0]         bank_req;
	logic [NUM_BANKS-1:0][WORD_W-1:0] bank_rdata;

	lpmr_ring_store u_store (
		.clk        (clk),
		.bank_req   (bank_req),
		.bank_rdata (bank_rdata)
	);

	assign used_bytes = tail_q - head_q;
	assign free_bytes = CHK_W'(BUFFER_BYTES) - CHK_W'(used_bytes);
	assign need_bytes = CHK_W'(req_s1.msg_size) + CHK_W'(RESERVE_BYTES);
	assign hdr_size   = bank_rdata[head_q[LANE_W]][SIZE_W-1:0];

	assign s2_free   = !rsp_vld_s2 || rsp_ready;
	assign s1_fire   = req_vld_s1 && s2_free && !need_fetch;
	assign fetch_go  = req_vld_s1 && s2_free && need_fetch;
	assign req_ready = !req_vld_s1 || s1_fire;

	always_comb begin
		head_d      = head_q;
		tail_d      = tail_q;
		wcur_d      = wcur_q;
		rcur_d      = rcur_q;
		push_left_d = push_left_q;
		pop_left_d  = pop_left_q;
		pop_len_d   = pop_len_q;
		push_rej_d  = push_rej_q;
		need_fetch  = 1'b0;
		hdr_we      = 1'b0;
		dat_we      = 1'b0;
		rd_re       = 1'b0;
		dat_pos     = wcur_q;
		rd_pos      = rcur_q;
		rsp_d       = '0;
		rsp_d.status = ST_OK;
		byte_vld_d  = 1'b0;
		case (req_s1.opcode)
			OP_PUSH: begin
				if (req_s1.push_start) begin
					// A new start abandons any unfinished push.
					push_left_d = '0;
					push_rej_d  = 1'b0;
					if (req_s1.msg_size == '0) begin
						rsp_d.end_of_message = 1'b1;
					end else if (free_bytes < need_bytes) begin
						push_rej_d   = 1'b1;
						push_left_d  = req_s1.msg_size - SIZE_W'(1);
						rsp_d.status = ST_NO_SPACE;
					end else begin
						hdr_we      = 1'b1;
						dat_we      = 1'b1;
						dat_pos     = tail_q + POS_W'(HDR_BYTES);
						wcur_d      = dat_pos + POS_W'(1);
						push_left_d = req_s1.msg_size - SIZE_W'(1);
						if (req_s1.msg_size == SIZE_W'(1)) begin
							tail_d               = round_pos(wcur_d);
							rsp_d.end_of_message = 1'b1;
						end
					end
				end else if (push_left_q == '0) begin
					rsp_d.status = ST_IGNORED;
				end else if (push_rej_q) begin
					push_left_d = push_left_q - SIZE_W'(1);
					if (push_left_q == SIZE_W'(1)) begin
						push_rej_d = 1'b0;
					end
					rsp_d.status = ST_IGNORED;
				end else begin
					dat_we      = 1'b1;
					dat_pos     = wcur_q;
					wcur_d      = wcur_q + POS_W'(1);
					push_left_d = push_left_q - SIZE_W'(1);
					if (push_left_q == SIZE_W'(1)) begin
						tail_d               = round_pos(wcur_d);
						rsp_d.end_of_message = 1'b1;
					end
				end
			end
			default: begin
				if (pop_left_q != '0) begin
					rd_re             = 1'b1;
					rd_pos            = rcur_q;
					rcur_d            = rcur_q + POS_W'(1);
					pop_left_d        = pop_left_q - SIZE_W'(1);
					rsp_d.popped_size = pop_len_q;
					byte_vld_d        = 1'b1;
					if (pop_left_q == SIZE_W'(1)) begin
						head_d               = round_pos(rcur_d);
						pop_len_d            = '0;
						rsp_d.end_of_message = 1'b1;
					end
				end else if (used_bytes <= POS_W'(HDR_BYTES)) begin
					rsp_d.status = ST_EMPTY;
				end else if (!hdr_ok_q) begin
					// The header word is fetched first; the request completes next cycle.
					need_fetch = 1'b1;
				end else begin
					rd_pos = head_q + POS_W'(HDR_BYTES);
					rcur_d = rd_pos;
					if (hdr_size == '0) begin
						head_d               = round_pos(rd_pos);
						rsp_d.end_of_message = 1'b1;
					end else begin
						rd_re             = 1'b1;
						rcur_d            = rd_pos + POS_W'(1);
						pop_left_d        = hdr_size - SIZE_W'(1);
						pop_len_d         = hdr_size;
						rsp_d.popped_size = hdr_size;
						byte_vld_d        = 1'b1;
						if (hdr_size == SIZE_W'(1)) begin
							head_d               = round_pos(rcur_d);
							pop_len_d            = '0;
							rsp_d.end_of_message = 1'b1;
						end
					end
				end
			end
		endcase
	end

	// Map the header write, the data write and the single read onto the two banks.
	always_comb begin
		for (int b = 0; b < NUM_BANKS; b++) begin
			bank_req[b].be    = '0;
			bank_req[b].waddr = dat_pos[POS_W-1:LANE_W+1];
			bank_req[b].wdata = {HDR_BYTES{req_s1.data_byte}};
			bank_req[b].re    = 1'b0;
			bank_req[b].raddr = rd_pos[POS_W-1:LANE_W+1];
			if (s1_fire && hdr_we && tail_q[LANE_W] == 1'(b)) begin
				bank_req[b].be    = '1;
				bank_req[b].waddr = tail_q[POS_W-1:LANE_W+1];
				bank_req[b].wdata = {(WORD_W - SIZE_W)'(0), req_s1.msg_size};
			end else if (s1_fire && dat_we && dat_pos[LANE_W] == 1'(b)) begin
				bank_req[b].be = HDR_BYTES'(1) << dat_pos[LANE_W-1:0];
			end
			if (fetch_go && head_q[LANE_W] == 1'(b)) begin
				bank_req[b].re    = 1'b1;
				bank_req[b].raddr = head_q[POS_W-1:LANE_W+1];
			end else if (s1_fire && rd_re && rd_pos[LANE_W] == 1'(b)) begin
				bank_req[b].re = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_vld_s1  <= 1'b0;
			rsp_vld_s2  <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			wcur_q      <= '0;
			rcur_q      <= '0;
			push_left_q <= '0;
			pop_left_q  <= '0;
			pop_len_q   <= '0;
			push_rej_q  <= 1'b0;
			hdr_ok_q    <= 1'b0;
		end else begin
			if (req_ready) begin
				req_vld_s1 <= req_valid;
			end
			if (s2_free) begin
				rsp_vld_s2 <= s1_fire;
			end
			if (s1_fire) begin
				head_q      <= head_d;
				tail_q      <= tail_d;
				wcur_q      <= wcur_d;
				rcur_q      <= rcur_d;
				push_left_q <= push_left_d;
				pop_left_q  <= pop_left_d;
				pop_len_q   <= pop_len_d;
				push_rej_q  <= push_rej_d;
				hdr_ok_q    <= 1'b0;
			end else if (fetch_go) begin
				hdr_ok_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (s1_fire) begin
			rsp_s2       <= rsp_d;
			byte_vld_s2  <= byte_vld_d;
			byte_bank_s2 <= rd_pos[LANE_W];
			byte_lane_s2 <= rd_pos[LANE_W-1:0];
		end
	end

	// The popped byte comes straight from the bank read register, which holds while stalled.
	always_comb begin
		rsp          = rsp_s2;
		rsp.out_byte = byte_vld_s2 ?
			bank_rdata[byte_bank_s2][byte_lane_s2 * BYTE_W +: BYTE_W] : '0;
	end

	assign rsp_valid = rsp_vld_s2;

`ifndef ASSERT_OFF
	a_hdr_ok_pop: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_ok_q |-> (req_vld_s1 && req_s1.opcode == OP_POP && pop_left_q == '0))
		else $error("header flag set without a waiting pop that opens a message");

	a_fetch_then_ok: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_go |=> (hdr_ok_q && !need_fetch))
		else $error("header fetch did not lead to a completing pop");

	a_bank_split: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && hdr_we && dat_we) |-> (tail_q[LANE_W] != dat_pos[LANE_W]))
		else $error("header and data writes collide in one bank");

	a_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q[LANE_W-1:0] == '0) && (tail_q[LANE_W-1:0] == '0))
		else $error("head or tail left a header boundary");
`endif

endmodule

>>> hdl/lpmr_ring_store.sv
// Byte store of the ring, split into two word-interleaved banks with byte write enables.
module lpmr_ring_store (
	input  logic                                            clk,
	input  lpmr_pkg::bank_req_t [lpmr_pkg::NUM_BANKS-1:0]   bank_req,
	output logic [lpmr_pkg::NUM_BANKS-1:0][lpmr_pkg::WORD_W-1:0] bank_rdata
);
	import lpmr_pkg::*;

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		logic [WORD_W-1:0] mem [BANK_DEPTH];

		always_ff @(posedge clk) begin
			for (int l = 0; l < HDR_BYTES; l++) begin
				if (bank_req[b].be[l]) begin
					mem[bank_req[b].waddr][l*BYTE_W +: BYTE_W] <=
						bank_req[b].wdata[l*BYTE_W +: BYTE_W];
				end
			end
			if (bank_req[b].re) begin
				bank_rdata[b] <= mem[bank_req[b].raddr];
			end
		end
	end

endmodule

>>> tb/sv/lpmr_ring_checker.sv
// Response checker for the length-prefixed message ring: predicts each response and compares.
`timescale 1ns / 1ps

module lpmr_ring_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_ready,
	input  lpmr_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  lpmr_pkg::rsp_t rsp,
	output int             errors,
	output int             pending
);
	import lpmr_pkg::*;

	localparam int MAX_PRINTED = 20;

	// Model of the ring: byte store, committed and working positions, message counters.
	logic [BYTE_W-1:0] ring_mem [BUFFER_BYTES];
	logic [POS_W-1:0]  head_at;
	logic [POS_W-1:0]  tail_at;
	logic [POS_W-1:0]  wr_at;
	logic [POS_W-1:0]  rd_at;
	logic [SIZE_W-1:0] push_todo;
	logic [SIZE_W-1:0] pop_todo;
	logic [SIZE_W-1:0] pop_len;
	logic              push_dropped;

	rsp_t due_rsp [$];
	rsp_t want;

	task automatic report(input string msg);
		errors++;
		if (errors <= MAX_PRINTED) begin
			$display("%0t ns: mismatch: %s", $time, msg);
		end
	endtask

	function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] p);
		int q;
		q = int'(p) + 1;
		return (q >= BUFFER_BYTES) ? '0 : POS_W'(q);
	endfunction

	// Committed positions land on a header boundary and wrap to zero at the end.
	function automatic logic [POS_W-1:0] align_pos(input logic [POS_W-1:0] p);
		int q;
		q = (int'(p) + HDR_BYTES - 1) / HDR_BYTES * HDR_BYTES;
		return (q >= BUFFER_BYTES) ? '0 : POS_W'(q);
	endfunction

	function automatic int ring_used();
		return (int'(tail_at) + BUFFER_BYTES - int'(head_at)) % BUFFER_BYTES;
	endfunction

	function automatic rsp_t ring_response(input req_t r);
		rsp_t              o;
		logic [POS_W-1:0]  p;
		logic [WORD_W-1:0] hdr;
		o = '0;
		o.status = ST_OK;
		if (r.opcode == OP_PUSH) begin
			if (r.push_start) begin
				// A new first byte always abandons whatever push was under way.
				push_todo = '0;
				push_dropped = 1'b0;
				if (r.msg_size == '0) begin
					o.end_of_message = 1'b1;
					return o;
				end
				if (BUFFER_BYTES - ring_used() < int'(r.msg_size) + RESERVE_BYTES) begin
					push_dropped = 1'b1;
					push_todo = r.msg_size - 1'b1;
					o.status = ST_NO_SPACE;
					return o;
				end
				hdr = WORD_W'(r.msg_size);
				p = tail_at;
				for (int i = 0; i < HDR_BYTES; i++) begin
					ring_mem[p] = hdr[BYTE_W*i +: BYTE_W];
					p = step_pos(p);
				end
				wr_at = p;
				push_todo = r.msg_size;
			end else if (push_todo == '0) begin
				o.status = ST_IGNORED;
				return o;
			end else if (push_dropped) begin
				push_todo = push_todo - 1'b1;
				if (push_todo == '0) begin
					push_dropped = 1'b0;
				end
				o.status = ST_IGNORED;
				return o;
			end
			ring_mem[wr_at] = r.data_byte;
			wr_at = step_pos(wr_at);
			push_todo = push_todo - 1'b1;
			if (push_todo == '0) begin
				tail_at = align_pos(wr_at);
				o.end_of_message = 1'b1;
			end
			return o;
		end
		if (pop_todo == '0) begin
			if (ring_used() <= HDR_BYTES) begin
				o.status = ST_EMPTY;
				return o;
			end
			hdr = '0;
			p = head_at;
			for (int i = 0; i < HDR_BYTES; i++) begin
				hdr[BYTE_W*i +: BYTE_W] = ring_mem[p];
				p = step_pos(p);
			end
			rd_at = p;
			if (hdr[SIZE_W-1:0] == '0) begin
				head_at = align_pos(rd_at);
				o.end_of_message = 1'b1;
				return o;
			end
			pop_todo = hdr[SIZE_W-1:0];
			pop_len = hdr[SIZE_W-1:0];
		end
		o.out_byte = ring_mem[rd_at];
		o.popped_size = pop_len;
		rd_at = step_pos(rd_at);
		pop_todo = pop_todo - 1'b1;
		if (pop_todo == '0) begin
			head_at = align_pos(rd_at);
			o.end_of_message = 1'b1;
			pop_len = '0;
		end
		return o;
	endfunction

	// Handshakes are sampled at the falling edge, where both sides are settled for the
	// rising edge that completes the transaction.
	always @(negedge clk) begin
		if (!arst_n) begin
			head_at = '0;
			tail_at = '0;
			wr_at = '0;
			rd_at = '0;
			push_todo = '0;
			pop_todo = '0;
			pop_len = '0;
			push_dropped = 1'b0;
			due_rsp.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (due_rsp.size() == 0) begin
					report("response transaction with no request outstanding");
				end else begin
					want = due_rsp.pop_front();
					if (rsp.out_byte !== want.out_byte) begin
						report($sformatf("out_byte got %0h want %0h", rsp.out_byte,
							want.out_byte));
					end
					if (rsp.popped_size !== want.popped_size) begin
						report($sformatf("popped_size got %0d want %0d", rsp.popped_size,
							want.popped_size));
					end
					if (rsp.end_of_message !== want.end_of_message) begin
						report($sformatf("end_of_message got %0b want %0b",
							rsp.end_of_message, want.end_of_message));
					end
					if (rsp.status !== want.status) begin
						report($sformatf("status got %0d want %0d", rsp.status, want.status));
					end
				end
			end
			if (req_valid && req_ready) begin
				due_rsp.push_back(ring_response(req));
			end
			pending = due_rsp.size();
		end
	end

endmodule

>>> tb/sv/tb_length_prefixed_message_ring.sv
// Top of the length-prefixed message ring testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_length_prefixed_message_ring;

	import lpmr_pkg::*;

	localparam int RANDOM_ITEMS = 450;
	localparam int LONG_HOLD    = 300;
	localparam int SETTLE       = 16;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int FILL_MSGS    = BUFFER_BYTES / (2 * HDR_BYTES) - 1;
	localparam int FILL_LAST    = HDR_BYTES;

	logic    clk;
	logic    arst_n = 1'b0;
	logic    req_valid = 1'b0;
	logic    req_ready;
	req_t    req = '0;
	logic    rsp_valid;
	logic    rsp_ready = 1'b0;
	rsp_t    rsp;

	int      errors;
	int      pending;
	int      cycles = 0;
	int      burst_left = 0;
	int      n_push = 0;
	int      n_pop = 0;
	int      n_msgs = 0;
	int      n_rsp = 0;
	logic    long_hold_req = 1'b0;
	bit      long_hold_done = 1'b0;
	status_t last_status = ST_OK;

	length_prefixed_message_ring dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	lpmr_ring_checker ring_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d responses outstanding.", cycles,
				pending);
			$display("length_prefixed_message_ring regression: fail");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			last_status <= rsp.status;
			n_rsp <= n_rsp + 1;
		end
	end

	// Receiver: switches between random stall patterns, and once holds off for a
	// long stretch so that the ring's pipeline backs up into the request channel.
	initial begin
		int mode;
		int span;
		int k;
		bit rdy;
		k = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 96);
			repeat (span) begin
				if (long_hold_req && !long_hold_done) begin
					rsp_ready <= 1'b0;
					repeat (LONG_HOLD) @(posedge clk);
					long_hold_done = 1'b1;
				end
				case (mode)
					0: rdy = 1'b1;
					1: rdy = ($urandom_range(0, 3) != 0);
					2: rdy = ($urandom_range(0, 3) == 0);
					default: rdy = ((k % 7) < 3);
				endcase
				k++;
				rsp_ready <= rdy;
				@(posedge clk);
			end
		end
	end

	function automatic req_t mk_req(input logic op, input logic start, input int size,
		input int data);
		req_t r;
		r.opcode = op;
		r.push_start = start;
		r.msg_size = SIZE_W'(size);
		r.data_byte = BYTE_W'(data);
		return r;
	endfunction

	// Pops ignore the other fields, so they carry random values.
	function automatic req_t pop_item();
		return mk_req(OP_POP, $urandom_range(0, 1), $urandom_range(0, BUFFER_BYTES),
			$urandom_range(0, 255));
	endfunction

	// Offers one transaction and returns at the edge that takes it. Valid stays high
	// within a burst and drops at its end, so a gap always follows a completed burst.
	task automatic send_req(input req_t item);
		bit taken;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(24, 64) :
				$urandom_range(1, 12);
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do begin
			@(negedge clk);
			taken = req_ready;
			@(posedge clk);
		end while (!taken);
		if (item.opcode == OP_PUSH) begin
			n_push++;
		end else begin
			n_pop++;
		end
		burst_left--;
		if (burst_left == 0) begin
			req_valid <= 1'b0;
		end
	endtask

	task automatic wait_idle();
		if (burst_left != 0) begin
			req_valid <= 1'b0;
			burst_left = 0;
		end
		while (pending != 0) @(posedge clk);
	endtask

	// Sends the first keep bytes (at least one) of a message of the given size, with pops mixed in.
	task automatic push_message(input int size, input int keep, input int pop_pct);
		int count;
		count = (keep > 0) ? keep : 1;
		n_msgs++;
		for (int i = 0; i < count; i++) begin
			if (i > 0 && $urandom_range(0, 99) < pop_pct) begin
				send_req(pop_item());
			end
			send_req(mk_req(OP_PUSH, i == 0, size, $urandom_range(0, 255)));
		end
	endtask

	task automatic pop_run(input int n);
		repeat (n) send_req(pop_item());
	endtask

	initial begin
		int  pick;
		int  size;
		int  keep;
		int  base;
		int  toggle_at;
		bit  fill;
		bit  paused;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty pop, stray byte, zero size, oversized reject with its
		// trailing bytes, restart over a rejected and over an accepted message.
		send_req(mk_req(OP_POP, 1'b0, 0, 0));
		send_req(mk_req(OP_PUSH, 1'b0, 7, 8'h3c));
		send_req(mk_req(OP_PUSH, 1'b1, 0, 8'hff));
		send_req(mk_req(OP_PUSH, 1'b1, BUFFER_BYTES, 8'hff));
		send_req(mk_req(OP_PUSH, 1'b0, BUFFER_BYTES, 8'h00));
		send_req(mk_req(OP_PUSH, 1'b0, BUFFER_BYTES, 8'h81));
		send_req(mk_req(OP_PUSH, 1'b1, 3, 8'h00));
		send_req(mk_req(OP_PUSH, 1'b0, 3, 8'hff));
		send_req(mk_req(OP_PUSH, 1'b0, 3, 8'ha5));
		send_req(mk_req(OP_PUSH, 1'b1, 5, 8'h11));
		send_req(mk_req(OP_PUSH, 1'b0, 5, 8'h22));
		send_req(mk_req(OP_PUSH, 1'b1, 2, 8'h5a));
		send_req(mk_req(OP_PUSH, 1'b0, 2, 8'h80));
		pop_run(6);
		send_req(mk_req(OP_PUSH, 1'b1, 1, 8'h01));
		pop_run(2);
		n_msgs += 6;

		// Random part: alternating fill and drain phases over random messages, some cut
		// short or oversized, with pops and stray bytes mixed in.
		long_hold_req <= 1'b1;
		base = n_push + n_pop;
		fill = 1'b1;
		paused = 1'b0;
		toggle_at = base + $urandom_range(150, 250);
		while (n_push + n_pop - base < RANDOM_ITEMS) begin
			if (n_push + n_pop >= toggle_at) begin
				fill = !fill;
				toggle_at = n_push + n_pop + $urandom_range(120, 300);
			end
			if (!paused && n_push + n_pop - base > RANDOM_ITEMS / 2) begin
				wait_idle();
				paused = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < (fill ? 80 : 25)) begin
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					size = 0;
				end else if (pick < 50) begin
					size = $urandom_range(1, 16);
				end else if (pick < 75) begin
					size = $urandom_range(17, 64);
				end else if (pick < 96) begin
					size = $urandom_range(65, 400);
				end else begin
					size = $urandom_range(BUFFER_BYTES - 3, BUFFER_BYTES);
				end
				keep = size;
				if (size > BUFFER_BYTES - HDR_BYTES) begin
					keep = $urandom_range(1, 6);
				end else if (size > 0 && $urandom_range(0, 99) < 8) begin
					keep = $urandom_range(1, size);
				end
				push_message(size, keep, fill ? 3 : 20);
			end else if (pick < 97) begin
				pop_run($urandom_range(1, fill ? 8 : 60));
			end else begin
				send_req(mk_req(OP_PUSH, 1'b0, $urandom_range(0, BUFFER_BYTES),
					$urandom_range(0, 255)));
			end
		end

		// Drain the ring, fill it with one-byte messages, then close it with a message that
		// takes exactly the space left: the tail comes back to the head and the ring reads
		// as empty.
		wait_idle();
		do begin
			send_req(pop_item());
			wait_idle();
		end while (last_status != ST_EMPTY);
		for (int i = 0; i < FILL_MSGS; i++) begin
			push_message(1, 1, 0);
		end
		push_message(FILL_LAST, FILL_LAST, 0);
		send_req(pop_item());
		push_message(5, 5, 0);
		pop_run(6);

		wait_idle();
		repeat (SETTLE) @(posedge clk);
		$display("Ran %0d push and %0d pop transactions over %0d messages; %0d checked.",
			n_push, n_pop, n_msgs, n_rsp);
		$display("Covered rejects, restarts, stray bytes, empty pops, a %0d-cycle stall %s",
			LONG_HOLD, "and a store filled to the last byte.");
		if (errors == 0) begin
			$display("length_prefixed_message_ring regression: pass");
		end else begin
			$display("length_prefixed_message_ring regression: fail");
		end
		$finish;
	end

endmodule
